>>> hw/rtl/ntbr_pkg.sv
package ntbr_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic signed [7:0] MAX_SNR_RST = 8'sd10;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // One stored neighbor entry
  typedef struct packed {
    logic [15:0]        id;
    logic [15:0]        metric;
    logic [7:0]         hops;
    logic signed [7:0]  snr;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_UPDATED = 2'd0,
    ST_ADDED   = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SCAN,
    S_DONE
  } state_e;

endpackage

>>> hw/rtl/neighbour_table_best_route.sv
// Neighbor table with best-route selection. Each input word is one received
// route beacon (sender id, hop count, cumulative metric, SNR). The link metric
// is metric_in + (max_snr - link_snr), clamped to 0..65535. An entry with the
// same id is overwritten; otherwise a new entry is appended while there is
// room, and the beacon is dropped (status 2) once all 16 entries are in use.
// After the update every valid entry is rescanned: lowest metric wins, and on
// an equal metric a later entry takes over if it has fewer hops or a
// strictly higher SNR. One result word per beacon carries the status,
// the best entry and the entry count. The table lives in one single-port-write
// RAM with a registered read, walked once for the id lookup and once for the
// best-route scan, one entry per cycle. After acceptance a beacon passes
// through the id lookup (which reads up to the match, else every valid
// entry), the table update and the scan of all entries after the update,
// and its result is then loaded into the output register. The input is
// ready again in the cycle after the load; a full output register holds
// the result back and so delays the next beacon.
// A new beacon is accepted while the previous result still waits in the
// output register.
// max_snr is written through cfg_we_i / cfg_wdata_i and must only change
// while the block is idle. The table starts empty after reset; no clearing
// pass is needed.
module neighbour_table_best_route (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  // beacon input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] sender_id_i,
  input  logic [7:0]  hop_count_i,
  input  logic [15:0] metric_in_i,
  input  logic [7:0]  link_snr_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [15:0] best_id_o,
  output logic [15:0] best_metric_o,
  output logic [7:0]  best_hops_o,
  output logic [7:0]  best_snr_o,
  output logic [4:0]  entry_count_o
);

  ntbr_pkg::state_e  state_q, state_d;
  ntbr_pkg::cnt_t    count_q, count_d;     // valid entries
  ntbr_pkg::cnt_t    scan_q, scan_d;       // next RAM address to read
  logic              pend_q, pend_d;       // read data arrives this cycle
  ntbr_pkg::idx_t    pend_idx_q, pend_idx_d;
  ntbr_pkg::status_e status_q, status_d;
  ntbr_pkg::entry_t  best_q, best_d;
  ntbr_pkg::entry_t  new_q, new_d;         // beacon as it will be stored
  logic signed [7:0] max_snr_q;

  // output register
  logic              out_valid_q, out_valid_d;
  logic              load_out;
  ntbr_pkg::status_e out_status_q;
  ntbr_pkg::entry_t  out_best_q;
  ntbr_pkg::cnt_t    out_count_q;

  // RAM port
  logic                          ram_we;
  ntbr_pkg::idx_t                ram_waddr;
  logic [ntbr_pkg::ENTRY_W-1:0]  ram_rdata;
  ntbr_pkg::entry_t              rd_entry;

  logic              hit;
  logic              issue;
  logic              better;
  logic signed [17:0] metric_sum;
  logic [15:0]       metric_sat;

  ntbr_ram #(
    .WIDTH(ntbr_pkg::ENTRY_W),
    .DEPTH(ntbr_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(new_q),
    .raddr_i(scan_q[ntbr_pkg::IDX_W-1:0]),
    .rdata_o(ram_rdata)
  );

  assign rd_entry = ntbr_pkg::entry_t'(ram_rdata);

  // Link metric with saturation, computed on the incoming beacon.
  always_comb begin
    metric_sum = $signed({2'b00, metric_in_i}) + 18'(max_snr_q) - 18'($signed(link_snr_i));
    if (metric_sum < 0) begin
      metric_sat = '0;
    end else if (metric_sum > 18'sd65535) begin
      metric_sat = 16'hFFFF;
    end else begin
      metric_sat = metric_sum[15:0];
    end
  end

  // Lookup and scan helpers
  assign hit   = pend_q && (rd_entry.id == new_q.id);
  assign issue = (scan_q < count_q);
  // Tie-break: on an equal metric, fewer hops or a strictly higher SNR wins.
  assign better = (pend_idx_q == '0) ||
                  (rd_entry.metric < best_q.metric) ||
                  ((rd_entry.metric == best_q.metric) &&
                   ((rd_entry.hops < best_q.hops) || (rd_entry.snr > best_q.snr)));

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    scan_d      = scan_q;
    pend_d      = 1'b0;
    pend_idx_d  = scan_q[ntbr_pkg::IDX_W-1:0];
    status_d    = status_q;
    best_d      = best_q;
    new_d       = new_q;
    ram_we      = 1'b0;
    ram_waddr   = pend_idx_q;
    load_out    = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;

    unique case (state_q)
      ntbr_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          new_d.id     = sender_id_i;
          new_d.metric = metric_sat;
          new_d.hops   = hop_count_i;
          new_d.snr    = $signed(link_snr_i);
          scan_d       = '0;
          state_d      = ntbr_pkg::S_SEARCH;
        end
      end

      // Walk the valid entries for a matching id.
      ntbr_pkg::S_SEARCH: begin
        if (hit) begin
          status_d = ntbr_pkg::ST_UPDATED;
          ram_we   = 1'b1;
          scan_d   = '0;
          best_d   = '0;
          state_d  = ntbr_pkg::S_SCAN;
        end else if (issue) begin
          pend_d = 1'b1;
          scan_d = scan_q + ntbr_pkg::cnt_t'(1);
        end else begin
          if (count_q < ntbr_pkg::cnt_t'(ntbr_pkg::TABLE_DEPTH)) begin
            status_d  = ntbr_pkg::ST_ADDED;
            ram_we    = 1'b1;
            ram_waddr = count_q[ntbr_pkg::IDX_W-1:0];
            count_d   = count_q + ntbr_pkg::cnt_t'(1);
          end else begin
            status_d = ntbr_pkg::ST_FULL;
          end
          scan_d  = '0;
          best_d  = '0;
          state_d = ntbr_pkg::S_SCAN;
        end
      end

      // Walk the table again for the best route.
      ntbr_pkg::S_SCAN: begin
        if (pend_q && better) begin
          best_d = rd_entry;
        end
        if (issue) begin
          pend_d = 1'b1;
          scan_d = scan_q + ntbr_pkg::cnt_t'(1);
        end else begin
          state_d = ntbr_pkg::S_DONE;
        end
      end

      ntbr_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ntbr_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = ntbr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ntbr_pkg::S_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      max_snr_q   <= ntbr_pkg::MAX_SNR_RST;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_q      <= scan_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        max_snr_q <= $signed(cfg_wdata_i);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    status_q   <= status_d;
    best_q     <= best_d;
    new_q      <= new_d;
    if (load_out) begin
      out_status_q <= status_q;
      out_best_q   <= best_q;
      out_count_q  <= count_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign best_id_o     = out_best_q.id;
  assign best_metric_o = out_best_q.metric;
  assign best_hops_o   = out_best_q.hops;
  assign best_snr_o    = out_best_q.snr;
  assign entry_count_o = 5'(out_count_q);

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ntbr_pkg::cnt_t'(ntbr_pkg::TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q >= $past(count_q))
    else $error("entry count decreased");

  a_accept_to_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ntbr_pkg::S_SEARCH)
    else $error("accepted beacon did not start lookup");

  a_result_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> entry_count_o != 5'd0)
    else $error("result reported with empty table");
`endif

endmodule

>>> hw/rtl/ntbr_ram.sv
module ntbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
